>>> hw/rtl/bmbi_pkg.sv
// Shared types and constants for the battery monitor blink indicator.
`timescale 1ns / 1ps

package bmbi_pkg;

    // Configuration register indexes
    typedef enum logic [1:0] {
        CFG_FULL_LEVEL = 2'd0,
        CFG_MID_LEVEL  = 2'd1,
        CFG_LOW_LEVEL  = 2'd2
    } t_cfg_reg;

    localparam logic [7:0] FULL_LEVEL_RST = 8'd130;
    localparam logic [7:0] MID_LEVEL_RST  = 8'd125;
    localparam logic [7:0] LOW_LEVEL_RST  = 8'd120;

    // Tick dividers, stored as terminal count (ticks minus one)
    localparam logic [4:0] PRESCALE_LAST = 5'd19;
    localparam logic [6:0] SLOW_LAST     = 7'd99;
    localparam logic [4:0] MEDIUM_LAST   = 5'd24;
    localparam logic [3:0] FAST_LAST     = 4'd11;

    // floor(adc*50/333) == (adc * 50 * ceil(2^24/333)) >> 24, exact for 10-bit adc
    localparam int         SCALE_SHIFT = 24;
    localparam logic [21:0] SCALE_MULT = 22'd2519150;

    typedef struct packed {
        logic [1:0] channel;
        logic       start;
        logic [7:0] total;
        logic [7:0] other_half;
        logic [7:0] half;
        logic [7:0] motor;
        logic [7:0] module_v;
    } t_scan_res;

    typedef struct packed {
        logic led;
        logic tick;
    } t_led_stat;

endpackage

>>> hw/rtl/bmbi_scale.sv
// Constant scaler: converter code to tenths of volts.
`timescale 1ns / 1ps

module bmbi_scale (
    input  logic [9:0] i_adc_result,
    output logic [7:0] o_volts
);

    logic [31:0] prod;

    assign prod    = {22'd0, i_adc_result} * {10'd0, bmbi_pkg::SCALE_MULT};
    assign o_volts = prod[bmbi_pkg::SCALE_SHIFT +: 8];

endmodule

>>> hw/rtl/bmbi_scan.sv
// Channel scan sequencer and voltage reading registers.
`timescale 1ns / 1ps

module bmbi_scan (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_en,
    input  logic                 i_busy,
    input  logic [7:0]           i_volts,
    output logic [7:0]           o_total_q,
    output bmbi_pkg::t_scan_res  o_nx
);

    logic [1:0] r_step, n_step;
    logic [1:0] r_chan, n_chan;
    logic [7:0] r_total, n_total;
    logic [7:0] r_half, n_half;
    logic [7:0] r_other, n_other;
    logic [7:0] r_motor, n_motor;
    logic [7:0] r_module, n_module;
    logic       start;

    always_comb begin
        n_step   = r_step;
        n_chan   = r_chan;
        n_total  = r_total;
        n_half   = r_half;
        n_other  = r_other;
        n_motor  = r_motor;
        n_module = r_module;
        start    = 1'b0;
        if (r_chan != r_step) begin
            n_chan = r_step;
            start  = 1'b1;
        end else if (!i_busy) begin
            case (r_step)
                2'd0: n_total = i_volts;
                2'd1: begin
                    n_half  = i_volts;
                    n_other = r_total - i_volts;
                end
                2'd2: n_motor = i_volts;
                default: n_module = i_volts;
            endcase
            n_step = r_step + 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step   <= '0;
            r_chan   <= '0;
            r_total  <= '0;
            r_half   <= '0;
            r_other  <= '0;
            r_motor  <= '0;
            r_module <= '0;
        end else if (i_en) begin
            r_step   <= n_step;
            r_chan   <= n_chan;
            r_total  <= n_total;
            r_half   <= n_half;
            r_other  <= n_other;
            r_motor  <= n_motor;
            r_module <= n_module;
        end
    end

    assign o_total_q       = r_total;
    assign o_nx.channel    = n_chan;
    assign o_nx.start      = start;
    assign o_nx.total      = n_total;
    assign o_nx.other_half = n_other;
    assign o_nx.half       = n_half;
    assign o_nx.motor      = n_motor;
    assign o_nx.module_v   = n_module;

endmodule

>>> hw/rtl/bmbi_led.sv
// Prescaler, blink timers and battery LED level.
`timescale 1ns / 1ps

module bmbi_led (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_en,
    input  logic [7:0]           i_total,
    input  logic [7:0]           i_full_level,
    input  logic [7:0]           i_mid_level,
    input  logic [7:0]           i_low_level,
    output bmbi_pkg::t_led_stat  o_stat
);

    logic [4:0] r_pre, n_pre;
    logic [6:0] r_slow, n_slow;
    logic [4:0] r_med, n_med;
    logic [3:0] r_fast, n_fast;
    logic       r_led, n_led;
    logic       tick;

    always_comb begin
        n_slow = r_slow;
        n_med  = r_med;
        n_fast = r_fast;
        n_led  = r_led;
        tick   = (r_pre == bmbi_pkg::PRESCALE_LAST);
        n_pre  = tick ? 5'd0 : r_pre + 5'd1;
        if (tick) begin
            if (i_total >= i_full_level) begin
                n_led = 1'b1;
            end
            // bands are tested in order; overlapping settings may toggle twice
            if (r_slow == bmbi_pkg::SLOW_LAST) begin
                n_slow = '0;
                if (i_total < i_full_level && i_total > i_mid_level) n_led = ~n_led;
            end else begin
                n_slow = r_slow + 7'd1;
            end
            if (r_med == bmbi_pkg::MEDIUM_LAST) begin
                n_med = '0;
                if (i_total <= i_mid_level && i_total > i_low_level) n_led = ~n_led;
            end else begin
                n_med = r_med + 5'd1;
            end
            if (r_fast == bmbi_pkg::FAST_LAST) begin
                n_fast = '0;
                if (i_total <= i_low_level) n_led = ~n_led;
            end else begin
                n_fast = r_fast + 4'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pre  <= '0;
            r_slow <= '0;
            r_med  <= '0;
            r_fast <= '0;
            r_led  <= 1'b1;
        end else if (i_en) begin
            r_pre  <= n_pre;
            r_slow <= n_slow;
            r_med  <= n_med;
            r_fast <= n_fast;
            r_led  <= n_led;
        end
    end

    assign o_stat.led  = n_led;
    assign o_stat.tick = tick;

endmodule

>>> hw/rtl/battery_monitor_blink_indicator.sv
// Top level: battery monitor with channel scan and blinking charge LED.
`timescale 1ns / 1ps
// An item loads into the input register when accepted and moves into the result
// register when that is empty or being drained. Throughput: one item per cycle
// unless the output stalls; the scan/LED update is one pass of logic.
// Reset (i_rst_n low, synchronous): pipeline empty, scan at channel 0, readings 0,
// timers 0, LED on, levels 130/125/120. No clearing pass.

module battery_monitor_blink_indicator (
    input  logic       i_clk,
    input  logic       i_rst_n,
    // input items: one per 1 kHz tick
    input  logic       i_in_valid,
    output logic       o_in_ready,
    input  logic       i_adc_busy,
    input  logic [9:0] i_adc_result,
    // result items
    output logic       o_out_valid,
    input  logic       i_out_ready,
    output logic       o_led_level,
    output logic [1:0] o_adc_channel,
    output logic       o_adc_start,
    output logic [7:0] o_battery_total,
    output logic [7:0] o_battery_one,
    output logic [7:0] o_battery_two,
    output logic [7:0] o_motor_volts,
    output logic [7:0] o_module_volts,
    output logic       o_timeout_tick,
    // configuration writes
    input  logic       i_cfg_valid,
    output logic       o_cfg_ready,
    input  logic [1:0] i_cfg_index,
    input  logic [7:0] i_cfg_data
);

    // ---------------- configuration registers ----------------
    logic [7:0] r_full_level, r_mid_level, r_low_level;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_full_level <= bmbi_pkg::FULL_LEVEL_RST;
            r_mid_level  <= bmbi_pkg::MID_LEVEL_RST;
            r_low_level  <= bmbi_pkg::LOW_LEVEL_RST;
        end else if (i_cfg_valid) begin
            unique case (bmbi_pkg::t_cfg_reg'(i_cfg_index))
                bmbi_pkg::CFG_FULL_LEVEL: r_full_level <= i_cfg_data;
                bmbi_pkg::CFG_MID_LEVEL:  r_mid_level  <= i_cfg_data;
                bmbi_pkg::CFG_LOW_LEVEL:  r_low_level  <= i_cfg_data;
                default: ;  // unused index, write dropped
            endcase
        end
    end

    // ---------------- input register ----------------
    logic       r_s1_valid;
    logic       r_s1_busy;
    logic [9:0] r_s1_result;
    logic       adv;   // item in input register moves into result register

    assign adv        = r_s1_valid && (!o_out_valid || i_out_ready);
    assign o_in_ready = !r_s1_valid || adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_s1_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_s1_busy   <= i_adc_busy;
            r_s1_result <= i_adc_result;
        end
    end

    // ---------------- update logic ----------------
    logic [7:0]          volts;
    logic [7:0]          total_q;
    bmbi_pkg::t_scan_res scan_nx;
    bmbi_pkg::t_led_stat led_nx;

    bmbi_scale u_scale (
        .i_adc_result (r_s1_result),
        .o_volts      (volts)
    );

    bmbi_scan u_scan (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_en      (adv),
        .i_busy    (r_s1_busy),
        .i_volts   (volts),
        .o_total_q (total_q),
        .o_nx      (scan_nx)
    );

    // LED sees the total as it stood before this item's conversion step
    bmbi_led u_led (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_en         (adv),
        .i_total      (total_q),
        .i_full_level (r_full_level),
        .i_mid_level  (r_mid_level),
        .i_low_level  (r_low_level),
        .o_stat       (led_nx)
    );

    // ---------------- result register ----------------
    logic                r_out_valid;
    logic [1:0]          r_out_channel;
    bmbi_pkg::t_scan_res r_out_scan;
    bmbi_pkg::t_led_stat r_out_led;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid   <= 1'b0;
            r_out_channel <= '0;
        end else begin
            if (adv) begin
                r_out_valid   <= 1'b1;
                r_out_channel <= scan_nx.channel;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_out_scan <= scan_nx;
            r_out_led  <= led_nx;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_led_level     = r_out_led.led;
    assign o_timeout_tick  = r_out_led.tick;
    assign o_adc_channel   = r_out_channel;
    assign o_adc_start     = r_out_scan.start;
    assign o_battery_total = r_out_scan.total;
    assign o_battery_one   = r_out_scan.other_half;
    assign o_battery_two   = r_out_scan.half;
    assign o_motor_volts   = r_out_scan.motor;
    assign o_module_volts  = r_out_scan.module_v;

    // ---------------- assertions ----------------
    a_adv_fills_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        adv |=> o_out_valid)
        else $error("advanced item did not reach result register");

    a_s1_kept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_s1_valid && !adv |=> r_s1_valid)
        else $error("stalled item lost from input register");

    a_start_on_change: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        adv && scan_nx.start |-> scan_nx.channel != r_out_channel)
        else $error("start pulsed without a channel change");

endmodule

>>> bench/battery_monitor_blink_indicator_test.sv
// Self-checking bench for the battery monitor: channel scan, scaling, LED blink, timeout tick.
`timescale 1ns / 1ps

module battery_monitor_blink_indicator_test;

    // Tick dividers and scale as the block's spec gives them
    localparam int LED_DIV     = 20;     // ticks per LED update / timeout tick
    localparam int SLOW_DIV    = 100;    // LED updates per slow toggle
    localparam int MID_DIV     = 25;     // LED updates per medium toggle
    localparam int FAST_DIV    = 12;     // LED updates per fast toggle
    localparam int SCALE_NUM   = 50;
    localparam int SCALE_DEN   = 333;
    localparam int PIPE_DELAY  = 1;      // item accept to result valid
    localparam int QUIET_LIMIT = 2000;   // cycles with no handshake before giving up
    localparam int RANDOM_ITEMS = 144;   // per phase; about 600 items in all

    // index 3 is not a register; a write there must change nothing
    localparam logic [1:0] CFG_SPARE_INDEX = 2'd3;

    typedef struct {
        logic       busy;
        logic [9:0] sample;
    } t_tick_in;

    typedef struct {
        logic       led;
        logic [1:0] channel;
        logic       start;
        logic [7:0] total;
        logic [7:0] one;
        logic [7:0] two;
        logic [7:0] motor;
        logic [7:0] modv;
        logic       tick;
    } t_tick_out;

    logic       i_clk          = 1'b0;
    logic       i_rst_n        = 1'b0;
    logic       i_in_valid     = 1'b0;
    logic       i_adc_busy     = 1'b0;
    logic [9:0] i_adc_result   = '0;
    logic       i_out_ready    = 1'b0;
    logic       i_cfg_valid    = 1'b0;
    logic [1:0] i_cfg_index    = '0;
    logic [7:0] i_cfg_data     = '0;
    logic       o_in_ready;
    logic       o_out_valid;
    logic       o_led_level;
    logic [1:0] o_adc_channel;
    logic       o_adc_start;
    logic [7:0] o_battery_total;
    logic [7:0] o_battery_one;
    logic [7:0] o_battery_two;
    logic [7:0] o_motor_volts;
    logic [7:0] o_module_volts;
    logic       o_timeout_tick;
    logic       o_cfg_ready;

    // Items waiting to be driven, and the readings they must produce
    t_tick_in  tick_queue[$];
    t_tick_out expected_ticks[$];
    int        fail_count     = 0;
    int        send_idle_pct  = 0;
    int        recv_stall_pct = 0;

    // Predictor state: thresholds, scan position, readings, blink timers
    logic [7:0] lvl_full = bmbi_pkg::FULL_LEVEL_RST;
    logic [7:0] lvl_mid  = bmbi_pkg::MID_LEVEL_RST;
    logic [7:0] lvl_low  = bmbi_pkg::LOW_LEVEL_RST;
    logic [1:0] scan_idx = '0;
    logic [1:0] sel_chan = '0;
    logic [7:0] v_total  = '0;
    logic [7:0] v_half   = '0;
    logic [7:0] v_other  = '0;
    logic [7:0] v_motor  = '0;
    logic [7:0] v_module = '0;
    logic [4:0] pre_cnt  = '0;
    logic [6:0] slow_cnt = '0;
    logic [4:0] mid_cnt  = '0;
    logic [3:0] fast_cnt = '0;
    logic       led_on   = 1'b1;

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    battery_monitor_blink_indicator uut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .o_in_ready      (o_in_ready),
        .i_adc_busy      (i_adc_busy),
        .i_adc_result    (i_adc_result),
        .o_out_valid     (o_out_valid),
        .i_out_ready     (i_out_ready),
        .o_led_level     (o_led_level),
        .o_adc_channel   (o_adc_channel),
        .o_adc_start     (o_adc_start),
        .o_battery_total (o_battery_total),
        .o_battery_one   (o_battery_one),
        .o_battery_two   (o_battery_two),
        .o_motor_volts   (o_motor_volts),
        .o_module_volts  (o_module_volts),
        .o_timeout_tick  (o_timeout_tick),
        .i_cfg_valid     (i_cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data)
    );

    // One 1 kHz tick of the monitor. The LED is judged on total_volts as it
    // stood before this tick's conversion step, so the blink logic runs first.
    function t_tick_out predict_tick(t_tick_in it);
        t_tick_out  r;
        logic [7:0] v;
        v       = 8'((int'(it.sample) * SCALE_NUM) / SCALE_DEN);
        r.tick  = 1'b0;
        r.start = 1'b0;
        pre_cnt = pre_cnt + 5'd1;
        if (pre_cnt == LED_DIV) begin
            r.tick  = 1'b1;
            pre_cnt = '0;
            // Bands are tested in a fixed order; odd thresholds may let
            // several toggles land on the same update.
            if (v_total >= lvl_full)
                led_on = 1'b1;
            slow_cnt = slow_cnt + 7'd1;
            if (slow_cnt == SLOW_DIV) begin
                if (v_total < lvl_full && v_total > lvl_mid)
                    led_on = ~led_on;
                slow_cnt = '0;
            end
            mid_cnt = mid_cnt + 5'd1;
            if (mid_cnt == MID_DIV) begin
                if (v_total <= lvl_mid && v_total > lvl_low)
                    led_on = ~led_on;
                mid_cnt = '0;
            end
            fast_cnt = fast_cnt + 4'd1;
            if (fast_cnt == FAST_DIV) begin
                if (v_total <= lvl_low)
                    led_on = ~led_on;
                fast_cnt = '0;
            end
        end
        // Channel change costs one tick with a start pulse; busy is ignored then.
        if (sel_chan != scan_idx) begin
            sel_chan = scan_idx;
            r.start  = 1'b1;
        end else if (!it.busy) begin
            case (scan_idx)
                2'd0: v_total = v;
                2'd1: begin
                    v_half  = v;
                    v_other = v_total - v;   // wraps mod 256
                end
                2'd2: v_motor = v;
                default: v_module = v;
            endcase
            scan_idx = scan_idx + 2'd1;
        end
        r.led     = led_on;
        r.channel = sel_chan;
        r.total   = v_total;
        r.one     = v_other;
        r.two     = v_half;
        r.motor   = v_motor;
        r.modv    = v_module;
        return r;
    endfunction

    task automatic check_field(string name, int want, int got);
        if (want != got) begin
            $display("%0t: %s expected %0d, got %0d", $time, name, want, got);
            fail_count++;
        end
    endtask

    task automatic push_item(logic busy, logic [9:0] sample);
        t_tick_in it;
        it.busy   = busy;
        it.sample = sample;
        tick_queue.push_back(it);
    endtask

    // Random ticks: many samples near the LED thresholds (adc 780..900 spans
    // roughly 117..135 tenths), some at the rails, the rest anywhere.
    task automatic queue_random(int count);
        int         pick;
        logic [9:0] sample;
        repeat (count) begin
            pick = $urandom_range(99);
            if (pick < 10)
                sample = $urandom_range(1) ? 10'h3FF : 10'h000;
            else if (pick < 55)
                sample = 10'($urandom_range(900, 780));
            else
                sample = 10'($urandom_range(1023, 0));
            push_item($urandom_range(99) < 30, sample);
        end
    endtask

    // Register write; only called with nothing in flight.
    task automatic write_level(logic [1:0] idx, logic [7:0] val);
        @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        case (idx)
            bmbi_pkg::CFG_FULL_LEVEL: lvl_full = val;
            bmbi_pkg::CFG_MID_LEVEL:  lvl_mid  = val;
            bmbi_pkg::CFG_LOW_LEVEL:  lvl_low  = val;
            default: ;
        endcase
    endtask

    // Wait until every queued item went in and every reading came back.
    task automatic settle();
        while (tick_queue.size() != 0 || i_in_valid || expected_ticks.size() != 0)
            @(posedge i_clk);
        repeat (PIPE_DELAY + 4) @(posedge i_clk);
    endtask

    // Driver: presents queued items, holds each until accepted, and runs the
    // predictor at the accepting edge.
    always @(posedge i_clk) begin : tick_driver
        t_tick_in nxt;
        t_tick_in cur;
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else begin
            if (i_in_valid && o_in_ready) begin
                cur.busy   = i_adc_busy;
                cur.sample = i_adc_result;
                expected_ticks.push_back(predict_tick(cur));
            end
            if (!i_in_valid || o_in_ready) begin
                if (tick_queue.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                    nxt = tick_queue.pop_front();
                    i_in_valid   <= 1'b1;
                    i_adc_busy   <= nxt.busy;
                    i_adc_result <= nxt.sample;
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    // Monitor: random back-pressure, every accepted reading checked in order.
    always @(posedge i_clk) begin : reading_monitor
        t_tick_out want;
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
        end else begin
            if (o_out_valid && i_out_ready) begin
                if (expected_ticks.size() == 0) begin
                    $display("%0t: reading with no item pending, expected none, got total %0d",
                             $time, o_battery_total);
                    fail_count++;
                end else begin
                    want = expected_ticks.pop_front();
                    check_field("led_level",    want.led,     o_led_level);
                    check_field("adc_channel",  want.channel, o_adc_channel);
                    check_field("adc_start",    want.start,   o_adc_start);
                    check_field("battery_total", want.total,  o_battery_total);
                    check_field("battery_one",  want.one,     o_battery_one);
                    check_field("battery_two",  want.two,     o_battery_two);
                    check_field("motor_volts",  want.motor,   o_motor_volts);
                    check_field("module_volts", want.modv,    o_module_volts);
                    check_field("timeout_tick", want.tick,    o_timeout_tick);
                end
            end
            i_out_ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // Watchdog: too long without any handshake means the block hung.
    initial begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < QUIET_LIMIT) begin
            @(posedge i_clk);
            if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)
                    || (i_cfg_valid && o_cfg_ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("TEST FAILED");
        $finish;
    end

    initial begin : stimulus
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Phase 0: reset thresholds, no idling on either side.
        // First scan: channel 0 already selected, so no start, read at once.
        push_item(1'b0, 10'd1023);   // total 153
        push_item(1'b0, 10'd0);      // select ch1, start
        push_item(1'b1, 10'd512);    // still converting
        push_item(1'b0, 10'd0);      // half 0, other half 153
        push_item(1'b0, 10'd0);      // select ch2
        push_item(1'b0, 10'd1023);   // motor 153
        push_item(1'b1, 10'd1023);   // select ch3; busy has no say on a change
        push_item(1'b0, 10'd0);      // module 0
        push_item(1'b0, 10'd5);      // back to ch0
        push_item(1'b1, 10'd333);
        push_item(1'b0, 10'd0);      // total 0
        push_item(1'b0, 10'd0);
        push_item(1'b0, 10'd1023);   // half 153, other half wraps to 103
        push_item(1'b1, 10'd0);
        push_item(1'b1, 10'd0);
        push_item(1'b0, 10'd512);    // motor 76
        push_item(1'b0, 10'd0);
        push_item(1'b0, 10'd1023);   // module 153
        push_item(1'b0, 10'd0);
        push_item(1'b0, 10'd866);    // total 130: right at full level
        push_item(1'b0, 10'd1);
        push_item(1'b0, 10'd833);    // 125: mid level
        push_item(1'b0, 10'd0);
        push_item(1'b0, 10'd800);    // 120: low level
        queue_random(RANDOM_ITEMS);
        settle();

        // Phase 1: never steady, slow band almost everywhere; sender idles.
        write_level(bmbi_pkg::CFG_FULL_LEVEL, 8'd255);
        write_level(bmbi_pkg::CFG_MID_LEVEL, 8'd0);
        write_level(bmbi_pkg::CFG_LOW_LEVEL, 8'd0);
        write_level(CFG_SPARE_INDEX, 8'hA5);
        send_idle_pct = 45;
        queue_random(RANDOM_ITEMS);
        settle();

        // Phase 2: always steady, yet fast toggle also fires on the same update.
        write_level(bmbi_pkg::CFG_FULL_LEVEL, 8'd0);
        write_level(bmbi_pkg::CFG_MID_LEVEL, 8'd255);
        write_level(bmbi_pkg::CFG_LOW_LEVEL, 8'd255);
        send_idle_pct  = 0;
        recv_stall_pct = 45;
        queue_random(RANDOM_ITEMS);
        settle();

        // Phase 3: random thresholds around the sample spread, bands may overlap.
        write_level(bmbi_pkg::CFG_FULL_LEVEL, 8'($urandom_range(140, 110)));
        write_level(bmbi_pkg::CFG_MID_LEVEL, 8'($urandom_range(140, 110)));
        write_level(bmbi_pkg::CFG_LOW_LEVEL, 8'($urandom_range(140, 110)));
        send_idle_pct  = 38;
        recv_stall_pct = 38;
        queue_random(RANDOM_ITEMS);
        settle();

        if (fail_count == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
